// ----- hdl/bba_pkg.sv -----
// Shared types, constants and control structs of the block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int unsigned MaxBlocks = 32;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = $clog2(MaxBlocks + 1);
  localparam int unsigned AddrW     = 32;
  localparam int unsigned BlkCntW   = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned DivCntW   = $clog2(AddrW + 1);

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE  = 2'd0,
    CFG_POOL  = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    COMMIT_NONE  = 2'd0,
    COMMIT_SET   = 2'd1,
    COMMIT_CLEAR = 2'd2
  } commit_e;

  typedef struct packed {
    logic cfg_wr;
    logic req_take;
    logic div_start;
    logic div_cfg;
    logic bb_zero;
    logic bb_load;
    logic alloc_find;
    logic alloc_fin;
    logic free_bad;
    logic free_fin;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_idx_ok;
    logic n_zero;
    logic req_free;
    logic free_bad;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/bba_req_if.sv -----
// Request channel interface: allocate or free transactions.
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [bba_pkg::AddrW-1:0]  free_address;

  modport source (output valid, output req_type, output free_address, input ready);
  modport sink   (input valid, input req_type, input free_address, output ready);
endinterface

`default_nettype wire

// ----- hdl/bba_rsp_if.sv -----
// Response channel interface: block address and status of each request.
`timescale 1ns / 1ps
`default_nettype none

interface bba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::AddrW-1:0]  block_address;
  logic [1:0]                 status;

  modport source (output valid, output block_address, output status, input ready);
  modport sink   (input valid, input block_address, input status, output ready);
endinterface

`default_nettype wire

// ----- hdl/bba_cfg_if.sv -----
// Configuration write channel interface: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface bba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::CfgIdxW-1:0]   index;
  logic [bba_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/bba_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bba_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [bba_pkg::AddrW-1:0]  dividend_i,
  input  wire logic [bba_pkg::AddrW-1:0]  divisor_i,
  output logic                            done_o,
  output logic [bba_pkg::AddrW-1:0]       quotient_o
);

  logic [bba_pkg::AddrW-1:0]   divisor_q, divisor_d;
  logic [bba_pkg::AddrW-1:0]   rem_q, rem_d;
  logic [bba_pkg::AddrW-1:0]   quo_q, quo_d;
  logic [bba_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [bba_pkg::AddrW:0]     trial;
  logic [bba_pkg::AddrW:0]     diff;

  always_comb begin
    trial     = {rem_q, quo_q[bba_pkg::AddrW-1]};
    diff      = trial - {1'b0, divisor_q};
    divisor_d = divisor_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    if (start_i) begin
      divisor_d = divisor_i;
      rem_d     = '0;
      quo_d     = dividend_i;
      cnt_d     = bba_pkg::DivCntW'(bba_pkg::AddrW);
    end else if (cnt_q != '0) begin
      // The partial remainder always stays below the divisor, so it fits AddrW bits.
      if (trial >= {1'b0, divisor_q}) begin
        rem_d = diff[bba_pkg::AddrW-1:0];
        quo_d = {quo_q[bba_pkg::AddrW-2:0], 1'b1};
      end else begin
        rem_d = trial[bba_pkg::AddrW-1:0];
        quo_d = {quo_q[bba_pkg::AddrW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - bba_pkg::DivCntW'(1);
      done_d = (cnt_q == bba_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- hdl/bba_dp.sv -----
// Datapath: configuration, bitmap, count, block search, address math and output register.
`timescale 1ns / 1ps
`default_nettype none

module bba_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bba_pkg::ctrl_cmd_t            cmd_i,
  output bba_pkg::dp_stat_t                  stat_o,
  input  wire logic [bba_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bba_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          req_type_i,
  input  wire logic [bba_pkg::AddrW-1:0]     free_address_i,
  output logic                               out_valid_o,
  output logic [bba_pkg::AddrW-1:0]          out_addr_o,
  output bba_pkg::status_e                   out_status_o,
  input  wire logic                          out_ready_i
);

  // Configuration and allocator state.
  logic [bba_pkg::AddrW-1:0]     base_q, base_d;
  logic [bba_pkg::AddrW-1:0]     pool_q, pool_d;
  logic [bba_pkg::BlkCntW-1:0]   bcnt_q, bcnt_d;
  logic [bba_pkg::AddrW-1:0]     bb_q, bb_d;
  logic [bba_pkg::MaxBlocks-1:0] map_q, map_d;
  logic [bba_pkg::CntW-1:0]      count_q, count_d;

  // Per-transaction working registers.
  logic [bba_pkg::AddrW-1:0]     addr_q, addr_d;
  logic                          hit_q, hit_d;
  logic [bba_pkg::IdxW-1:0]      idx_q, idx_d;
  logic [bba_pkg::AddrW-1:0]     prod_q, prod_d;
  logic [bba_pkg::AddrW-1:0]     res_addr_q, res_addr_d;
  bba_pkg::status_e              res_status_q, res_status_d;
  bba_pkg::commit_e              commit_q, commit_d;
  logic [bba_pkg::IdxW-1:0]      cidx_q, cidx_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [bba_pkg::AddrW-1:0]     out_addr_q, out_addr_d;
  bba_pkg::status_e              out_status_q, out_status_d;

  logic [bba_pkg::CntW-1:0]          n_live;
  logic [bba_pkg::MaxBlocks-1:0]     avail;
  logic                              found;
  logic [bba_pkg::IdxW-1:0]          fidx;
  logic [bba_pkg::AddrW+bba_pkg::IdxW-1:0] prod_full;
  logic [bba_pkg::AddrW-1:0]         div_dividend;
  logic [bba_pkg::AddrW-1:0]         div_divisor;
  logic                              div_done;
  logic [bba_pkg::AddrW-1:0]         quotient;
  logic                              cfg_idx_ok;

  bba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    if (int'(bcnt_q) > bba_pkg::MaxBlocks) begin
      n_live = bba_pkg::CntW'(bba_pkg::MaxBlocks);
    end else begin
      n_live = bba_pkg::CntW'(bcnt_q);
    end
  end

  // Lowest free block below the live count; the last hit in a downward scan wins.
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = 0; i < bba_pkg::MaxBlocks; i++) begin
      avail[i] = !map_q[i] && (i < int'(n_live));
    end
    for (int i = bba_pkg::MaxBlocks - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found = 1'b1;
        fidx  = bba_pkg::IdxW'(i);
      end
    end
  end

  assign prod_full    = bb_q * fidx;
  assign div_dividend = cmd_i.div_cfg ? pool_q : (addr_q - base_q);
  assign div_divisor  = cmd_i.div_cfg ? bba_pkg::AddrW'(n_live) : bb_q;

  assign cfg_idx_ok = (cfg_index_i == bba_pkg::CFG_BASE) ||
                      (cfg_index_i == bba_pkg::CFG_POOL) ||
                      (cfg_index_i == bba_pkg::CFG_COUNT);

  always_comb begin
    stat_o.cfg_idx_ok = cfg_idx_ok;
    stat_o.n_zero     = (n_live == '0);
    stat_o.req_free   = (req_type_i == bba_pkg::REQ_FREE);
    stat_o.free_bad   = (bb_q == '0) || (addr_q < base_q);
    stat_o.div_done   = div_done;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    base_d       = base_q;
    pool_d       = pool_q;
    bcnt_d       = bcnt_q;
    bb_d         = bb_q;
    map_d        = map_q;
    count_d      = count_q;
    addr_d       = addr_q;
    hit_d        = hit_q;
    idx_d        = idx_q;
    prod_d       = prod_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    commit_d     = commit_q;
    cidx_d       = cidx_q;
    out_valid_d  = out_valid_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;

    if (cmd_i.cfg_wr) begin
      case (cfg_index_i)
        bba_pkg::CFG_BASE:  base_d = cfg_data_i[bba_pkg::AddrW-1:0];
        bba_pkg::CFG_POOL:  pool_d = cfg_data_i[bba_pkg::AddrW-1:0];
        bba_pkg::CFG_COUNT: bcnt_d = cfg_data_i[bba_pkg::BlkCntW-1:0];
        default:            ;
      endcase
      if (cfg_idx_ok) begin
        map_d   = '0;
        count_d = '0;
      end
    end

    if (cmd_i.bb_zero) begin
      bb_d = '0;
    end
    if (cmd_i.bb_load) begin
      bb_d = quotient;
    end

    if (cmd_i.req_take) begin
      addr_d = free_address_i;
    end

    if (cmd_i.alloc_find) begin
      hit_d  = found && (count_q < n_live);
      idx_d  = fidx;
      prod_d = prod_full[bba_pkg::AddrW-1:0];
    end

    if (cmd_i.alloc_fin) begin
      cidx_d = idx_q;
      if (hit_q) begin
        res_addr_d   = base_q + prod_q;
        res_status_d = bba_pkg::STATUS_OK;
        commit_d     = bba_pkg::COMMIT_SET;
      end else begin
        res_addr_d   = '0;
        res_status_d = bba_pkg::STATUS_FULL;
        commit_d     = bba_pkg::COMMIT_NONE;
      end
    end

    if (cmd_i.free_bad) begin
      res_addr_d   = '0;
      res_status_d = bba_pkg::STATUS_RANGE;
      commit_d     = bba_pkg::COMMIT_NONE;
    end

    if (cmd_i.free_fin) begin
      res_addr_d = '0;
      cidx_d     = quotient[bba_pkg::IdxW-1:0];
      if (quotient >= bba_pkg::AddrW'(n_live)) begin
        res_status_d = bba_pkg::STATUS_RANGE;
        commit_d     = bba_pkg::COMMIT_NONE;
      end else begin
        res_status_d = bba_pkg::STATUS_OK;
        commit_d     = bba_pkg::COMMIT_CLEAR;
      end
    end

    // Only a config write or a result moving to the output register changes bitmap and count.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d  = 1'b1;
      out_addr_d   = res_addr_q;
      out_status_d = res_status_q;
      case (commit_q)
        bba_pkg::COMMIT_SET: begin
          map_d[cidx_q] = 1'b1;
          count_d       = count_q + bba_pkg::CntW'(1);
        end
        bba_pkg::COMMIT_CLEAR: begin
          map_d[cidx_q] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - bba_pkg::CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      pool_q      <= '0;
      bcnt_q      <= '0;
      bb_q        <= '0;
      map_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      pool_q      <= pool_d;
      bcnt_q      <= bcnt_d;
      bb_q        <= bb_d;
      map_q       <= map_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    hit_q        <= hit_d;
    idx_q        <= idx_d;
    prod_q       <= prod_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    commit_q     <= commit_d;
    cidx_q       <= cidx_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

// ----- hdl/bba_ctrl.sv -----
// Controller state machine that sequences configuration, allocate and free transactions.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire bba_pkg::dp_stat_t  stat_i,
  output bba_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CFG   = 8'b0000_0010,
    S_CDIV  = 8'b0000_0100,
    S_AFIND = 8'b0000_1000,
    S_AFIN  = 8'b0001_0000,
    S_FCHK  = 8'b0010_0000,
    S_FDIV  = 8'b0100_0000,
    S_RES   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cfg_ready_o = 1'b1;
        // A configuration write takes precedence over a request in the same cycle.
        req_ready_o = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_wr = 1'b1;
          if (stat_i.cfg_idx_ok) begin
            state_d = S_CFG;
          end
        end else if (req_valid_i) begin
          cmd_o.req_take = 1'b1;
          state_d = stat_i.req_free ? S_FCHK : S_AFIND;
        end
      end
      S_CFG: begin
        if (stat_i.n_zero) begin
          cmd_o.bb_zero = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_cfg   = 1'b1;
          state_d = S_CDIV;
        end
      end
      S_CDIV: begin
        cmd_o.div_cfg = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.bb_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_AFIND: begin
        cmd_o.alloc_find = 1'b1;
        state_d = S_AFIN;
      end
      S_AFIN: begin
        cmd_o.alloc_fin = 1'b1;
        state_d = S_RES;
      end
      S_FCHK: begin
        if (stat_i.free_bad) begin
          cmd_o.free_bad = 1'b1;
          state_d = S_RES;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_FDIV;
        end
      end
      S_FDIV: begin
        if (stat_i.div_done) begin
          cmd_o.free_fin = 1'b1;
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bitmap_block_allocator_top.sv -----
// Allocate: after acceptance the search (S_AFIND), the result step (S_AFIN) and S_RES run in order.
// Free: the range check (S_FCHK) and the 32-step serial divider (S_FDIV) run before S_RES.
// A free below the base or with zero-size blocks skips the divider and goes from S_FCHK straight to S_RES.
// One transaction is in work at a time; the next is accepted once the result is in the output register.
// A write to a known register rebuilds the block size in the divider, or zeroes it if no block is live.
// Reset (asynchronous, active low) clears the registers, the used bitmap, the count and the block size.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bba_req_if.sink    req_i,
  bba_rsp_if.source  rsp_o,
  bba_cfg_if.sink    cfg_i
);

  bba_pkg::ctrl_cmd_t cmd;
  bba_pkg::dp_stat_t  stat;
  bba_pkg::status_e   out_status;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .req_type_i     (req_i.req_type),
    .free_address_i (req_i.free_address),
    .out_valid_o    (rsp_o.valid),
    .out_addr_o     (rsp_o.block_address),
    .out_status_o   (out_status),
    .out_ready_i    (rsp_o.ready)
  );

  assign rsp_o.status = out_status;

`ifndef SYNTHESIS
  a_no_dual_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.valid && req_i.ready && cfg_i.valid && cfg_i.ready))
    else $error("request and configuration accepted in the same cycle");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request channel ready while a transaction is in work");

  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.ready &&
     (cfg_i.index == bba_pkg::CFG_BASE || cfg_i.index == bba_pkg::CFG_POOL ||
      cfg_i.index == bba_pkg::CFG_COUNT)) |=> !req_i.ready)
    else $error("request accepted before the block size was rebuilt");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != bba_pkg::STATUS_OK) |-> (rsp_o.block_address == '0))
    else $error("failed transaction returned a nonzero block address");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the bitmap block allocator: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [bba_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned RandomReqs = 930;

  typedef enum logic [1:0] {
    OP_REQ   = 2'd0,
    OP_CFG   = 2'd1,
    OP_DRAIN = 2'd2
  } op_kind_e;

  typedef struct {
    op_kind_e                     kind;
    bba_pkg::req_type_e           req;
    logic [bba_pkg::AddrW-1:0]    addr;
    logic [bba_pkg::CfgIdxW-1:0]  idx;
    logic [bba_pkg::CfgDataW-1:0] data;
    int unsigned                  gap;
  } stim_op_t;

  typedef struct packed {
    logic [bba_pkg::AddrW-1:0] block_address;
    bba_pkg::status_e          status;
  } alloc_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();
  bba_cfg_if cfg_if ();

  bitmap_block_allocator_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  stim_op_t   stim_q[$];
  alloc_rsp_t due_rsp_q[$];
  int unsigned mismatch_cnt = 0;

  // Predictor state: registers, used bitmap, allocation count and block size.
  logic [bba_pkg::AddrW-1:0]     m_base;
  logic [bba_pkg::AddrW-1:0]     m_pool;
  logic [bba_pkg::BlkCntW-1:0]   m_count;
  logic [bba_pkg::MaxBlocks-1:0] m_used;
  logic [bba_pkg::BlkCntW-1:0]   m_used_cnt;
  logic [bba_pkg::AddrW-1:0]     m_blk_bytes;

  function automatic int unsigned blocks_live();
    return (m_count > bba_pkg::MaxBlocks) ? bba_pkg::MaxBlocks : int'(m_count);
  endfunction

  function automatic void pool_reconfigure(logic [bba_pkg::CfgIdxW-1:0] idx,
                                           logic [bba_pkg::CfgDataW-1:0] data);
    int unsigned n;
    case (idx)
      bba_pkg::CFG_BASE:  m_base = data;
      bba_pkg::CFG_POOL:  m_pool = data;
      bba_pkg::CFG_COUNT: m_count = data[bba_pkg::BlkCntW-1:0];
      default:            return;
    endcase
    n = blocks_live();
    m_used = '0;
    m_used_cnt = '0;
    m_blk_bytes = (n == 0) ? '0 : m_pool / n;
  endfunction

  function automatic alloc_rsp_t serve_request(bba_pkg::req_type_e req,
                                               logic [bba_pkg::AddrW-1:0] addr);
    alloc_rsp_t  r;
    int unsigned n;
    logic [bba_pkg::AddrW-1:0] idx;
    bit found;
    n = blocks_live();
    r.block_address = '0;
    r.status = bba_pkg::STATUS_OK;
    found = 1'b0;
    if (req == bba_pkg::REQ_ALLOC) begin
      if (m_used_cnt < n) begin
        for (int unsigned i = 0; i < n; i++) begin
          if (!found && !m_used[i]) begin
            m_used[i] = 1'b1;
            m_used_cnt = m_used_cnt + 1'b1;
            r.block_address = m_base + m_blk_bytes * i;
            found = 1'b1;
          end
        end
      end
      if (!found) r.status = bba_pkg::STATUS_FULL;
    end else if (m_blk_bytes == 0 || addr < m_base) begin
      r.status = bba_pkg::STATUS_RANGE;
    end else begin
      idx = (addr - m_base) / m_blk_bytes;
      if (idx >= n) begin
        r.status = bba_pkg::STATUS_RANGE;
      end else begin
        // Freeing a clear block still lowers the count, which never goes below zero.
        m_used[idx[bba_pkg::IdxW-1:0]] = 1'b0;
        if (m_used_cnt != 0) m_used_cnt = m_used_cnt - 1'b1;
      end
    end
    return r;
  endfunction

  // Request and configuration driver.
  int unsigned hold_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    logic req_v;
    logic cfg_v;
    stim_op_t op;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      cfg_if.valid <= 1'b0;
      hold_cnt = 0;
      m_base = '0;
      m_pool = '0;
      m_count = '0;
      m_used = '0;
      m_used_cnt = '0;
      m_blk_bytes = '0;
    end else begin
      req_v = req_if.valid;
      cfg_v = cfg_if.valid;
      if (req_v && req_if.ready) begin
        due_rsp_q.push_back(serve_request(bba_pkg::req_type_e'(req_if.req_type),
                                          req_if.free_address));
        req_v = 1'b0;
      end
      if (cfg_v && cfg_if.ready) begin
        pool_reconfigure(cfg_if.index, cfg_if.data);
        cfg_v = 1'b0;
      end
      if (!req_v && !cfg_v && stim_q.size() != 0) begin
        op = stim_q[0];
        if (op.kind == OP_REQ) begin
          if (hold_cnt < op.gap) begin
            hold_cnt++;
          end else begin
            void'(stim_q.pop_front());
            hold_cnt = 0;
            req_if.req_type <= op.req;
            req_if.free_address <= op.addr;
            req_v = 1'b1;
          end
        end else if (due_rsp_q.size() == 0) begin
          // Register writes and pauses wait until every response is back.
          void'(stim_q.pop_front());
          if (op.kind == OP_CFG) begin
            cfg_if.index <= op.idx;
            cfg_if.data <= op.data;
            cfg_v = 1'b1;
          end
        end
      end
      req_if.valid <= req_v;
      cfg_if.valid <= cfg_v;
    end
  end

  // Response monitor with random back-pressure.
  int unsigned stall_cnt;
  bit          rsp_calm;

  function automatic void log_mismatch(string what, alloc_rsp_t want);
    if (mismatch_cnt < 10)
      $display("%s: expected addr %h status %0d, got addr %h status %0d", what,
               want.block_address, want.status, rsp_if.block_address, rsp_if.status);
    mismatch_cnt++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic rdy;
    alloc_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_cnt = 0;
      rsp_calm = 1'b0;
    end else begin
      rdy = rsp_if.ready;
      if (rsp_if.valid && rdy) begin
        if (due_rsp_q.size() == 0) begin
          want = '0;
          log_mismatch("response with no request outstanding", want);
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_if.block_address !== want.block_address || rsp_if.status !== want.status)
            log_mismatch("response mismatch", want);
        end
        if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
        stall_cnt = rsp_calm ? 0 : $urandom_range(0, 4);
        rdy = (stall_cnt == 0);
      end else if (!rdy) begin
        if (stall_cnt != 0) stall_cnt--;
        if (stall_cnt == 0) rdy = 1'b1;
      end
      rsp_if.ready <= rdy;
    end
  end

  // Stimulus generation. The g_ copies track the pool layout to aim frees at real blocks.
  bit                        calm = 1'b0;
  int unsigned               req_total = 0;
  logic [bba_pkg::AddrW-1:0] g_base = '0;
  logic [bba_pkg::AddrW-1:0] g_pool = '0;
  int unsigned               g_cnt = 0;
  int unsigned               g_n = 0;
  logic [bba_pkg::AddrW-1:0] g_blk = '0;

  task automatic push_req(bba_pkg::req_type_e req, logic [bba_pkg::AddrW-1:0] addr);
    stim_op_t op;
    if ($urandom_range(0, 24) == 0) calm = !calm;
    op.kind = OP_REQ;
    op.req  = req;
    op.addr = addr;
    op.idx  = bba_pkg::CFG_BASE;
    op.data = '0;
    op.gap  = calm ? 0 : $urandom_range(0, 4);
    stim_q.push_back(op);
    req_total++;
  endtask

  task automatic push_cfg(logic [bba_pkg::CfgIdxW-1:0] idx,
                          logic [bba_pkg::CfgDataW-1:0] data);
    stim_op_t op;
    op.kind = OP_CFG;
    op.req  = bba_pkg::REQ_ALLOC;
    op.addr = '0;
    op.idx  = idx;
    op.data = data;
    op.gap  = 0;
    stim_q.push_back(op);
    case (idx)
      bba_pkg::CFG_BASE:  g_base = data;
      bba_pkg::CFG_POOL:  g_pool = data;
      bba_pkg::CFG_COUNT: g_cnt = data[bba_pkg::BlkCntW-1:0];
      default:            ;
    endcase
    g_n = (g_cnt > bba_pkg::MaxBlocks) ? bba_pkg::MaxBlocks : g_cnt;
    g_blk = (g_n == 0) ? '0 : g_pool / g_n;
  endtask

  task automatic push_drain();
    stim_op_t op;
    op.kind = OP_DRAIN;
    op.req  = bba_pkg::REQ_ALLOC;
    op.addr = '0;
    op.idx  = bba_pkg::CFG_BASE;
    op.data = '0;
    op.gap  = 0;
    stim_q.push_back(op);
  endtask

  function automatic logic [bba_pkg::AddrW-1:0] pick_free_address();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (g_blk != 0 && r < 70)
      return g_base + g_blk * $urandom_range(0, g_n - 1) + $urandom_range(0, g_blk - 1);
    if (r < 82) return g_base + g_blk * g_n + $urandom_range(0, 300);
    if (r < 92) return g_base - $urandom_range(1, 300);
    return $urandom();
  endfunction

  initial begin
    logic [bba_pkg::AddrW-1:0]    base;
    logic [bba_pkg::AddrW-1:0]    pool;
    int unsigned                  cnt;
    int unsigned                  first;
    int unsigned                  len;
    logic [bba_pkg::CfgIdxW-1:0]  reg_order[3];

    req_if.valid = 1'b0;
    req_if.req_type = bba_pkg::REQ_ALLOC;
    req_if.free_address = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = bba_pkg::CFG_BASE;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;

    // With no blocks configured every allocation fails and every free is out of range.
    push_req(bba_pkg::REQ_ALLOC, 32'h0);
    push_req(bba_pkg::REQ_FREE, 32'h0);
    // Four blocks of 0x100 bytes at 0x1000.
    push_cfg(bba_pkg::CFG_BASE, 32'h0000_1000);
    push_cfg(bba_pkg::CFG_POOL, 32'h0000_0400);
    push_cfg(bba_pkg::CFG_COUNT, 32'd4);
    repeat (5) push_req(bba_pkg::REQ_ALLOC, 32'hFFFF_FFFF);
    push_req(bba_pkg::REQ_FREE, 32'h0000_1107);
    push_req(bba_pkg::REQ_FREE, 32'h0000_0FFF);
    push_req(bba_pkg::REQ_FREE, 32'h0000_1400);
    push_req(bba_pkg::REQ_FREE, 32'h0000_1100);
    push_req(bba_pkg::REQ_ALLOC, 32'h0);
    // The count now says room is left but every block is marked used.
    push_req(bba_pkg::REQ_ALLOC, 32'h0);
    push_cfg(bba_pkg::CFG_COUNT, 32'hFFFF_FFC0);
    push_req(bba_pkg::REQ_ALLOC, 32'h0);
    push_req(bba_pkg::REQ_FREE, 32'h0000_1000);
    // Count above the maximum, full-size pool near the top of the address space.
    push_cfg(bba_pkg::CFG_BASE, 32'hFFFF_FF00);
    push_cfg(bba_pkg::CFG_POOL, 32'hFFFF_FFFF);
    push_cfg(bba_pkg::CFG_COUNT, 32'd63);
    push_req(bba_pkg::REQ_FREE, 32'hFFFF_FFFF);
    push_req(bba_pkg::REQ_ALLOC, 32'h0);
    push_req(bba_pkg::REQ_ALLOC, 32'h0);
    push_req(bba_pkg::REQ_FREE, 32'h0000_0000);
    // Pool smaller than the block count gives zero-byte blocks.
    push_cfg(bba_pkg::CFG_POOL, 32'd5);
    push_cfg(bba_pkg::CFG_COUNT, 32'd8);
    push_req(bba_pkg::REQ_ALLOC, 32'h0);
    push_req(bba_pkg::REQ_FREE, 32'hFFFF_FF00);
    push_cfg(CfgUnused, $urandom());
    push_req(bba_pkg::REQ_ALLOC, 32'h0);
    push_drain();

    while (req_total < RandomReqs + 25) begin
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = $urandom();
        2:       base = 32'hFFFF_FFFF - $urandom_range(0, 4095);
        default: base = $urandom_range(0, 65535) << 4;
      endcase
      case ($urandom_range(0, 11))
        0:       cnt = 0;
        1:       cnt = $urandom_range(33, 63);
        2, 3, 4: cnt = $urandom_range(1, 6);
        default: cnt = $urandom_range(1, 32);
      endcase
      case ($urandom_range(0, 4))
        0:       pool = $urandom();
        1:       pool = 32'hFFFF_FFFF;
        2:       pool = $urandom_range(0, 40);
        default: pool = ((cnt > bba_pkg::MaxBlocks) ? bba_pkg::MaxBlocks : cnt)
                        * $urandom_range(1, 4096) + $urandom_range(0, 7);
      endcase
      reg_order[0] = bba_pkg::CFG_BASE;
      reg_order[1] = bba_pkg::CFG_POOL;
      reg_order[2] = bba_pkg::CFG_COUNT;
      first = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        case (reg_order[(first + k) % 3])
          bba_pkg::CFG_BASE: push_cfg(bba_pkg::CFG_BASE, base);
          bba_pkg::CFG_POOL: push_cfg(bba_pkg::CFG_POOL, pool);
          default:           push_cfg(bba_pkg::CFG_COUNT, ($urandom() & 32'hFFFF_FFC0) | cnt);
        endcase
      end
      if ($urandom_range(0, 9) == 0) push_cfg(CfgUnused, $urandom());
      len = $urandom_range(10, 60);
      for (int unsigned j = 0; j < len; j++) begin
        if ($urandom_range(0, 49) == 0) push_drain();
        if ($urandom_range(0, 99) < 55) push_req(bba_pkg::REQ_ALLOC, $urandom());
        else push_req(bba_pkg::REQ_FREE, pick_free_address());
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || req_if.valid || cfg_if.valid || due_rsp_q.size() != 0)
      @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
